// ----- src/complex_arithmetic_unit_top_macros.svh -----
// Assertion macros shared by the checker of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cau_pkg.sv -----
// Shared types, constants and tables of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int CORDIC_STAGES = 16;
    localparam int ANG_BITS      = 30;
    localparam int SQRT_STEPS    = 16;
    localparam int QBITS         = 16;
    localparam int MID_STAGES    = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int QDEPTH        = 4;

    localparam int CW     = 16 + ANG_BITS + 3;
    localparam int ZW     = 34;
    localparam int DW     = 34;
    localparam int DEG_K  = 180 * (2 ** (FRAC_BITS + 1));
    localparam int DEG_W  = $clog2(DEG_K + 1);
    localparam int PW     = 32 + DEG_W;
    localparam int RW_A   = (PW > DW + QBITS) ? PW : DW + QBITS;
    localparam int RW     = RW_A + 2;
    localparam int SATW   = 36;

    localparam logic [33:0] PI_Q30 = 34'd3373259426;

    localparam logic [31:0] ATAN_TAB [10] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149
    };

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MAG  = 4'd4,
        OP_CONJ = 4'd5,
        OP_ANG  = 4'd6,
        OP_REAL = 4'd7,
        OP_IMAG = 4'd8,
        OP_NONE = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } st_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } item_t;

    // CORDIC angle constant for stage i, Q2.30 radians
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        if (i < 10)
            return ZW'(ATAN_TAB[i]);
        else
            return ZW'((64'd1 << ANG_BITS) >> i);
    endfunction

endpackage

`default_nettype wire

// ----- src/cau_front.sv -----
// Front end: accepts request items, classifies the action code, feeds the queue.
`default_nettype none

module cau_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire  [3:0]          action,
    input  wire  signed [15:0]  a_re,
    input  wire  signed [15:0]  a_im,
    input  wire  signed [15:0]  b_re,
    input  wire  signed [15:0]  b_im,
    output logic                out_valid,
    input  wire                 out_ready,
    output cau_pkg::item_t      out_item
);
    import cau_pkg::*;

    logic  vld_reg, vld_next;
    item_t item_reg, item_next;
    logic  take;

    function automatic op_t classify(input logic [3:0] code);
        if (code <= 4'(OP_IMAG))
            return op_t'(code);
        else
            return OP_NONE;
    endfunction

    assign req_ready = !vld_reg || out_ready;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        item_next      = item_reg;
        item_next.op   = classify(action);
        item_next.a_re = a_re;
        item_next.a_im = a_im;
        item_next.b_re = b_re;
        item_next.b_im = b_im;
        if (take)
            vld_next = 1'b1;
        else if (out_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign out_valid = vld_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- src/cau_queue.sv -----
// Short FIFO between the front end and the execution pipeline.
`default_nettype none

module cau_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push_valid,
    output logic            push_ready,
    input  cau_pkg::item_t  push_item,
    output logic            pop_valid,
    input  wire             pop_ready,
    output cau_pkg::item_t  pop_item
);
    import cau_pkg::*;

    localparam int QAW = $clog2(QDEPTH);

    item_t          fifo_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           push, pop;

    assign push_ready = cnt_reg != (QAW+1)'(QDEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- src/cau_back.sv -----
// Execution pipeline: products, CORDIC, square root, divider and saturation.
`default_nettype none

module cau_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  cau_pkg::item_t      in_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic signed [15:0]  res_re,
    output logic signed [15:0]  res_im,
    output logic [1:0]          status
);
    import cau_pkg::*;

    localparam int MID_BASE = 3;
    localparam int P1_IDX   = MID_BASE + MID_STAGES;
    localparam int P2_IDX   = P1_IDX + 1;
    localparam int D0_IDX   = P1_IDX + 2;
    localparam int DQ_BASE  = P1_IDX + 3;
    localparam int FIN_IDX  = DQ_BASE + QBITS;
    localparam int NSTG     = FIN_IDX + 1;

    localparam logic signed [SATW-1:0] SAT_MAX = SATW'(32767);
    localparam logic signed [SATW-1:0] SAT_MIN = -SATW'(32768);

    typedef struct packed {
        logic signed [15:0] v;
        logic               sat;
    } sat_t;

    typedef struct packed {
        logic             act;
        logic             neg;
        logic             ovf;
        logic [RW-1:0]    num;
        logic [DW-1:0]    den;
        logic [QBITS-1:0] q;
    } lane_t;

    typedef struct packed {
        op_t                  op;
        logic                 azero;
        logic signed [15:0]   fin_re;
        logic signed [15:0]   fin_im;
        st_t                  fin_st;
        logic signed [31:0]   p0;
        logic signed [31:0]   p1;
        logic signed [31:0]   p2;
        logic signed [31:0]   p3;
        logic signed [31:0]   p4;
        logic signed [31:0]   p5;
        logic signed [33:0]   sa;
        logic signed [33:0]   sb;
        logic [32:0]          sc;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] cz;
        logic [15:0]          root;
        logic [33:0]          rem_s;
        logic                 zneg;
        logic [PW-1:0]        prod;
        lane_t                lre;
        lane_t                lim;
    } pipe_t;

    function automatic sat_t sat16(input logic signed [SATW-1:0] x);
        sat_t r;
        r.sat = 1'b0;
        r.v   = x[15:0];
        if (x > SAT_MAX)
        begin
            r.sat = 1'b1;
            r.v   = 16'sh7fff;
        end
        else if (x < SAT_MIN)
        begin
            r.sat = 1'b1;
            r.v   = 16'sh8000;
        end
        return r;
    endfunction

    // operand products, simple results, CORDIC setup
    function automatic pipe_t f_s1(input item_t it);
        pipe_t              p;
        logic signed [17:0] sr;
        logic signed [17:0] si;
        logic signed [15:0] xs;
        logic signed [15:0] ys;
        logic signed [16:0] cxi;
        logic signed [16:0] cyi;
        sat_t               tr;
        sat_t               ti;
        p        = '0;
        p.op     = it.op;
        p.fin_st = ST_OK;
        xs   = (it.op == OP_MAG) ? it.a_re : it.b_re;
        ys   = (it.op == OP_MAG) ? it.a_im : it.b_im;
        p.p0 = it.a_re * it.b_re;
        p.p1 = it.a_im * it.b_im;
        p.p2 = it.a_re * it.b_im;
        p.p3 = it.a_im * it.b_re;
        p.p4 = xs * xs;
        p.p5 = ys * ys;
        sr   = '0;
        si   = '0;
        case (it.op)
            OP_ADD:
            begin
                sr = 18'(it.a_re) + 18'(it.b_re);
                si = 18'(it.a_im) + 18'(it.b_im);
            end
            OP_SUB:
            begin
                sr = 18'(it.a_re) - 18'(it.b_re);
                si = 18'(it.a_im) - 18'(it.b_im);
            end
            OP_CONJ:
            begin
                sr = 18'(it.a_re);
                si = -18'(it.a_im);
            end
            OP_REAL: sr = 18'(it.a_re);
            OP_IMAG: sr = 18'(it.a_im);
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        tr       = sat16(SATW'(sr));
        ti       = sat16(SATW'(si));
        p.fin_re = tr.v;
        p.fin_im = ti.v;
        if (tr.sat || ti.sat)
            p.fin_st = ST_SAT;
        p.azero = (it.a_re == 16'sd0);
        if (it.a_re < 16'sd0)
        begin
            cxi = -17'(it.a_re);
            cyi = -17'(it.a_im);
        end
        else
        begin
            cxi = 17'(it.a_re);
            cyi = 17'(it.a_im);
        end
        p.cx = CW'(cxi) <<< ANG_BITS;
        p.cy = CW'(cyi) <<< ANG_BITS;
        if (it.op == OP_ANG && p.azero)
            p.fin_st = ST_ZERO;
        return p;
    endfunction

    // sums of products
    function automatic pipe_t f_s2(input pipe_t s);
        pipe_t p;
        p = s;
        if (s.op == OP_MUL)
        begin
            p.sa = 34'(s.p0) - 34'(s.p1);
            p.sb = 34'(s.p2) + 34'(s.p3);
        end
        else
        begin
            p.sa = 34'(s.p0) + 34'(s.p1);
            p.sb = 34'(s.p3) - 34'(s.p2);
        end
        p.sc = 33'($unsigned(s.p4)) + 33'($unsigned(s.p5));
        return p;
    endfunction

    // product rounding, divider and square root setup
    function automatic pipe_t f_s3(input pipe_t s);
        pipe_t              p;
        logic [33:0]        ma;
        logic [33:0]        mb;
        logic [33:0]        ra;
        logic [33:0]        rb;
        logic signed [33:0] va;
        logic signed [33:0] vb;
        sat_t               tr;
        sat_t               ti;
        p  = s;
        ma = (s.sa < 34'sd0) ? 34'(-s.sa) : 34'(s.sa);
        mb = (s.sb < 34'sd0) ? 34'(-s.sb) : 34'(s.sb);
        ra = (ma + (34'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rb = (mb + (34'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        va = (s.sa < 34'sd0) ? -$signed(ra) : $signed(ra);
        vb = (s.sb < 34'sd0) ? -$signed(rb) : $signed(rb);
        p.rem_s = 34'(s.sc);
        p.root  = '0;
        if (s.op == OP_MUL)
        begin
            tr       = sat16(SATW'(va));
            ti       = sat16(SATW'(vb));
            p.fin_re = tr.v;
            p.fin_im = ti.v;
            if (tr.sat || ti.sat)
                p.fin_st = ST_SAT;
        end
        else if (s.op == OP_DIV)
        begin
            if (s.sc == '0)
                p.fin_st = ST_ZERO;
            else
            begin
                p.lre.act = 1'b1;
                p.lre.neg = s.sa < 34'sd0;
                p.lre.num = (RW'(ma) << (FRAC_BITS + 1)) + RW'(s.sc);
                p.lre.den = DW'(s.sc) << 1;
                p.lim.act = 1'b1;
                p.lim.neg = s.sb < 34'sd0;
                p.lim.num = (RW'(mb) << (FRAC_BITS + 1)) + RW'(s.sc);
                p.lim.den = DW'(s.sc) << 1;
            end
        end
        return p;
    endfunction

    // one CORDIC rotation and one square root digit
    function automatic pipe_t f_mid(input pipe_t s, input int i);
        pipe_t                p;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic [33:0]          trial;
        int                   k;
        p = s;
        if (i < CORDIC_STAGES)
        begin
            dx = s.cy >>> i;
            dy = s.cx >>> i;
            if (s.cy > 0)
            begin
                p.cx = s.cx + dx;
                p.cy = s.cy - dy;
                p.cz = s.cz + atan_entry(i);
            end
            else
            begin
                p.cx = s.cx - dx;
                p.cy = s.cy + dy;
                p.cz = s.cz - atan_entry(i);
            end
        end
        if (i < SQRT_STEPS)
        begin
            k     = SQRT_STEPS - 1 - i;
            trial = (34'(s.root) << (k + 1)) + (34'(1) << (2 * k));
            if (s.rem_s >= trial)
            begin
                p.rem_s = s.rem_s - trial;
                p.root  = s.root | (16'(1) << k);
            end
        end
        return p;
    endfunction

    // angle in radians, degree product, magnitude rounding
    function automatic pipe_t f_p1(input pipe_t s);
        pipe_t                p;
        logic [ZW-1:0]        az;
        logic [ZW-1:0]        rr;
        logic signed [ZW-1:0] vr;
        logic [16:0]          mr;
        sat_t                 tr;
        p      = s;
        az     = (s.cz < 0) ? ZW'(-s.cz) : ZW'(s.cz);
        p.zneg = s.cz < 0;
        p.prod = PW'(az[31:0]) * PW'(DEG_K);
        rr     = (az + (ZW'(1) << (ANG_BITS - FRAC_BITS - 1))) >> (ANG_BITS - FRAC_BITS);
        vr     = p.zneg ? -$signed(rr) : $signed(rr);
        mr     = 17'(s.root) + 17'(s.rem_s > 34'(s.root));
        if (s.op == OP_ANG && !s.azero)
        begin
            tr       = sat16(SATW'(vr));
            p.fin_re = tr.v;
            if (tr.sat)
                p.fin_st = ST_SAT;
        end
        else if (s.op == OP_MAG)
        begin
            if (mr > 17'd32767)
            begin
                p.fin_re = 16'sh7fff;
                p.fin_st = ST_SAT;
            end
            else
                p.fin_re = $signed(mr[15:0]);
        end
        return p;
    endfunction

    // degrees: round(|z| * 180 * 2^F / pi) through the imaginary divider lane
    function automatic pipe_t f_p2(input pipe_t s);
        pipe_t p;
        p = s;
        if (s.op == OP_ANG && !s.azero)
        begin
            p.lim.act = 1'b1;
            p.lim.neg = s.zneg;
            p.lim.num = RW'(s.prod) + RW'(PI_Q30);
            p.lim.den = DW'(PI_Q30) << 1;
        end
        return p;
    endfunction

    function automatic lane_t lane_d0(input lane_t l);
        lane_t r;
        r     = l;
        r.ovf = l.num >= (RW'(l.den) << QBITS);
        r.q   = '0;
        return r;
    endfunction

    function automatic lane_t lane_step(input lane_t l, input int k);
        lane_t         r;
        logic [RW-1:0] t;
        r = l;
        t = RW'(l.den) << k;
        if (l.num >= t)
        begin
            r.num = l.num - t;
            r.q   = l.q | (QBITS'(1) << k);
        end
        return r;
    endfunction

    function automatic sat_t lane_val(input lane_t l);
        sat_t               r;
        logic signed [17:0] v;
        v = l.neg ? -$signed({2'b00, l.q}) : $signed({2'b00, l.q});
        r = sat16(SATW'(v));
        if (l.ovf)
        begin
            r.sat = 1'b1;
            r.v   = l.neg ? 16'sh8000 : 16'sh7fff;
        end
        return r;
    endfunction

    function automatic pipe_t f_d0(input pipe_t s);
        pipe_t p;
        p     = s;
        p.lre = lane_d0(s.lre);
        p.lim = lane_d0(s.lim);
        return p;
    endfunction

    function automatic pipe_t f_dq(input pipe_t s, input int k);
        pipe_t p;
        p     = s;
        p.lre = lane_step(s.lre, k);
        p.lim = lane_step(s.lim, k);
        return p;
    endfunction

    function automatic pipe_t f_fin(input pipe_t s);
        pipe_t p;
        sat_t  tr;
        sat_t  ti;
        p  = s;
        tr = lane_val(s.lre);
        ti = lane_val(s.lim);
        if (s.lre.act)
            p.fin_re = tr.v;
        if (s.lim.act)
            p.fin_im = ti.v;
        if ((s.lre.act && tr.sat) || (s.lim.act && ti.sat))
            p.fin_st = ST_SAT;
        return p;
    endfunction

    pipe_t           stg_reg  [NSTG];
    pipe_t           stg_next [NSTG];
    logic [NSTG-1:0] vld_reg, vld_next;
    logic            adv;

    assign adv      = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    for (genvar g = 0; g < NSTG; g++)
    begin : g_stg
        if (g == 0)
        begin : g_s1
            assign stg_next[g] = f_s1(in_item);
        end
        else if (g == 1)
        begin : g_s2
            assign stg_next[g] = f_s2(stg_reg[g-1]);
        end
        else if (g == 2)
        begin : g_s3
            assign stg_next[g] = f_s3(stg_reg[g-1]);
        end
        else if (g < P1_IDX)
        begin : g_mid
            assign stg_next[g] = f_mid(stg_reg[g-1], g - MID_BASE);
        end
        else if (g == P1_IDX)
        begin : g_p1
            assign stg_next[g] = f_p1(stg_reg[g-1]);
        end
        else if (g == P2_IDX)
        begin : g_p2
            assign stg_next[g] = f_p2(stg_reg[g-1]);
        end
        else if (g == D0_IDX)
        begin : g_d0
            assign stg_next[g] = f_d0(stg_reg[g-1]);
        end
        else if (g < FIN_IDX)
        begin : g_dq
            assign stg_next[g] = f_dq(stg_reg[g-1], QBITS - 1 - (g - DQ_BASE));
        end
        else
        begin : g_fin
            assign stg_next[g] = f_fin(stg_reg[g-1]);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stg_reg[g] <= stg_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    assign out_valid = vld_reg[NSTG-1];
    assign res_re    = stg_reg[NSTG-1].fin_re;
    assign res_im    = stg_reg[NSTG-1].fin_im;
    assign status    = stg_reg[NSTG-1].fin_st;

endmodule

`default_nettype wire

// ----- src/complex_arithmetic_unit_top.sv -----
// Top level of the complex arithmetic unit: front end, queue and execution pipeline.
//
// Request channel (req_valid/req_ready) carries one item: action code plus two
// complex operands a and b in signed Q7.8. Response channel (rsp_valid/rsp_ready)
// returns res_re, res_im and status (ok, saturated, zero divisor/operand).
// Every item gives exactly one response, in order.
//
// Throughput: one item per cycle while the receiver does not stall. Every action
// runs down the same fixed pipeline: products, 16 CORDIC / square root stages,
// a 16-step restoring divider (complex quotient and radians-to-degrees scaling),
// saturation. With no stall, an accepted request passes the front register, a
// queue slot and the 39 execution stages, the last of which holds the response.
//
// A stalled receiver freezes the execution pipeline; the front end keeps taking
// items until the 4-entry queue and the front register are full, then drops
// req_ready. Reset (rst_n low, asynchronous) empties the pipeline and queue;
// no clearing pass, items are accepted in the first cycle after reset.
`default_nettype none

module complex_arithmetic_unit_top (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_ready,
    input  wire  [3:0]         action,
    input  wire  signed [15:0] a_re,
    input  wire  signed [15:0] a_im,
    input  wire  signed [15:0] b_re,
    input  wire  signed [15:0] b_im,
    output logic               rsp_valid,
    input  wire                rsp_ready,
    output logic signed [15:0] res_re,
    output logic signed [15:0] res_im,
    output logic [1:0]         status
);
    import cau_pkg::*;

    // front end -> queue
    logic  fq_valid, fq_ready;
    item_t fq_item;
    // queue -> execution
    logic  qb_valid, qb_ready;
    item_t qb_item;

    cau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .action    (action),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    cau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // pipeline's last stage doubles as the response register
    cau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- src/cau_checker.sv -----
// Port-level assertions for the complex arithmetic unit, bound to the top level.
`default_nettype none

`include "complex_arithmetic_unit_top_macros.svh"

module cau_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               rsp_valid,
    input wire               rsp_ready,
    input wire signed [15:0] res_re,
    input wire signed [15:0] res_im,
    input wire [1:0]         status
);
    import cau_pkg::*;

    // stalled response must hold
    `CAU_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(res_re) && $stable(res_im) && $stable(status), "response changed under stall")

    // zero divisor or zero operand yields a zero result
    `CAU_ASSERT_IMP(a_zero_res, rsp_valid && (status == ST_ZERO), (res_re == 16'sd0) && (res_im == 16'sd0), "nonzero result with zero status")

    // saturation flag implies a clipped part
    `CAU_ASSERT_IMP(a_sat_clip, rsp_valid && (status == ST_SAT), (res_re == 16'sh7fff) || (res_re == 16'sh8000) || (res_im == 16'sh7fff) || (res_im == 16'sh8000), "saturated status without clipped part")

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);

`default_nettype wire

// ----- tb/complex_arithmetic_unit_checker.sv -----
// Scoreboard for the complex arithmetic unit: predicts each item's result and compares responses.
`timescale 1ns / 1ps

module complex_arithmetic_unit_checker
    import cau_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    input  wire               req_ready,
    input  wire  [3:0]        action,
    input  wire signed [15:0] a_re,
    input  wire signed [15:0] a_im,
    input  wire signed [15:0] b_re,
    input  wire signed [15:0] b_im,
    input  wire               rsp_valid,
    input  wire               rsp_ready,
    input  wire signed [15:0] res_re,
    input  wire signed [15:0] res_im,
    input  wire  [1:0]        status,
    output int                fail_count,
    output int                pending,
    output int                seen
);

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        st_t                st;
    } cplx_res_t;

    cplx_res_t expected_q[$];

    function automatic longint unsigned absval(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int s);
        longint unsigned r;
        r = (absval(v) + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint round_quot(longint num, longint den);
        longint unsigned q;
        q = (absval(num) * (64'd1 << FRAC_BITS) * 2 + longint'(den)) / (2 * longint'(den));
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp16(longint v, inout st_t st);
        if (v > 32767) begin
            st = ST_SAT;
            return 32767;
        end
        if (v < -32768) begin
            st = ST_SAT;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint root_rounded(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        if (v - lo * lo > lo) lo++;
        return lo;
    endfunction

    // vectoring CORDIC, angle in Q2.30 radians
    function automatic longint cordic_angle(longint x, longint y);
        longint z, nx, step;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
        end
        x = x * (longint'(1) << ANG_BITS);
        y = y * (longint'(1) << ANG_BITS);
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            step = (i < 10) ? longint'(ATAN_TAB[i]) : ((longint'(1) << ANG_BITS) >>> i);
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += step;
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= step;
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic cplx_res_t predict_result(logic [3:0] act, longint ar, longint ai,
                                                 longint br, longint bi);
        cplx_res_t r;
        longint re, im, den, z;
        longint unsigned q, pi_q;
        st_t st;
        re = 0;
        im = 0;
        st = ST_OK;
        pi_q = longint'(PI_Q30);
        case (act)
            OP_ADD: begin re = ar + br; im = ai + bi; end
            OP_SUB: begin re = ar - br; im = ai - bi; end
            OP_MUL: begin
                re = round_shift(ar * br - ai * bi, FRAC_BITS);
                im = round_shift(ar * bi + ai * br, FRAC_BITS);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) st = ST_ZERO;
                else begin
                    re = round_quot(ar * br + ai * bi, den);
                    im = round_quot(ai * br - ar * bi, den);
                end
            end
            OP_MAG:  re = root_rounded(ar * ar + ai * ai);
            OP_CONJ: begin re = ar; im = -ai; end
            OP_ANG: begin
                if (ar == 0) st = ST_ZERO;
                else begin
                    z  = cordic_angle(ar, ai);
                    re = round_shift(z, ANG_BITS - FRAC_BITS);
                    q  = (absval(z) * 180 * (64'd1 << FRAC_BITS) * 2 + pi_q) / (2 * pi_q);
                    im = (z < 0) ? -longint'(q) : longint'(q);
                end
            end
            OP_REAL: re = ar;
            OP_IMAG: re = ai;
            default: ;
        endcase
        r.re = 16'(clamp16(re, st));
        r.im = 16'(clamp16(im, st));
        r.st = st;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        cplx_res_t want;
        if (!rst_n) begin
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
            seen       <= 0;
        end else begin
            if (req_valid && req_ready)
                expected_q.push_back(predict_result(action, a_re, a_im, b_re, b_im));
            if (rsp_valid && rsp_ready) begin
                seen <= seen + 1;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: response with nothing expected: re=%0d im=%0d st=%0d",
                                 res_re, res_im, status);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.re !== res_re || want.im !== res_im || want.st !== status) begin
                        if (fail_count < 10)
                            $display("ERROR: mismatch exp re=%0d im=%0d st=%0d got re=%0d im=%0d st=%0d",
                                     want.re, want.im, want.st, res_re, res_im, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

// ----- tb/tb_complex_arithmetic_unit_top.sv -----
// Testbench top for the complex arithmetic unit: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_top;
    import cau_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [3:0]         action = '0;
    logic signed [15:0] a_re = '0;
    logic signed [15:0] a_im = '0;
    logic signed [15:0] b_re = '0;
    logic signed [15:0] b_im = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic [1:0]         status;

    int fail_count, pending, seen;

    // idle percentages of the current phase, read by sender and receiver
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold = 1'b0;
    int sent = 0;

    always #5 clk = ~clk;

    complex_arithmetic_unit_top dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .action(action),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .res_re(res_re), .res_im(res_im), .status(status)
    );

    complex_arithmetic_unit_checker scoreboard (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .action(action),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
        .res_re(res_re), .res_im(res_im), .status(status),
        .fail_count(fail_count), .pending(pending), .seen(seen)
    );

    // Receiver: random stalls per phase; on request, one long hold-off so the
    // pipeline and input queue fill and req_ready drops.
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                rsp_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item, called at a rising edge. An optional gap drops valid first.
    // Acceptance is read at the falling edge, where req_ready is settled.
    task automatic offer_item(logic [3:0] act, logic [15:0] ar, logic [15:0] ai,
                              logic [15:0] br, logic [15:0] bi);
        bit taken;
        if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= act;
        a_re      <= ar;
        a_im      <= ai;
        b_re      <= br;
        b_im      <= bi;
        do begin
            @(negedge clk);
            taken = req_ready;
            @(posedge clk);
        end while (!taken);
        sent++;
    endtask

    // Operand mix: full range for bit coverage, small values so that mul,
    // div and angle land in range, and a few extremes.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5, 6:    return 16'($signed($urandom_range(0, 1023)) - 512);
            7:          return 16'($signed($urandom_range(0, 15)) - 8);
            8:          return $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default:    return 16'h0000;
        endcase
    endfunction

    task automatic random_items(int count);
        logic [3:0] act;
        logic [15:0] ar, ai, br, bi;
        for (int n = 0; n < count; n++) begin
            // mostly defined actions, a few unused codes
            act = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(8));
            ar = pick_operand();
            ai = pick_operand();
            br = pick_operand();
            bi = pick_operand();
            if (act == OP_DIV && $urandom_range(9) == 0) begin
                br = '0;
                bi = '0;
            end
            if (act == OP_ANG && $urandom_range(9) == 0)
                ar = '0;
            offer_item(act, ar, ai, br, bi);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every action, zero divisor, zero angle operand,
        // conjugate of the most negative value, unused codes
        offer_item(OP_ADD,  16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        offer_item(OP_ADD,  16'h0100, 16'hff00, 16'h0080, 16'h0040);
        offer_item(OP_SUB,  16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        offer_item(OP_SUB,  16'h0300, 16'h0200, 16'h0100, 16'h0400);
        offer_item(OP_MUL,  16'h8000, 16'h8000, 16'h8000, 16'h8000);
        offer_item(OP_MUL,  16'h0180, 16'hff80, 16'h0200, 16'h0100);
        offer_item(OP_DIV,  16'h0100, 16'h0200, 16'h0000, 16'h0000);
        offer_item(OP_DIV,  16'h0300, 16'h0100, 16'h0100, 16'hff00);
        offer_item(OP_DIV,  16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
        offer_item(OP_MAG,  16'h8000, 16'h8000, 16'h0000, 16'h0000);
        offer_item(OP_MAG,  16'h0300, 16'h0400, 16'h0000, 16'h0000);
        offer_item(OP_CONJ, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        offer_item(OP_CONJ, 16'h1234, 16'h7fff, 16'h0000, 16'h0000);
        offer_item(OP_ANG,  16'h0000, 16'h0100, 16'h0000, 16'h0000);
        offer_item(OP_ANG,  16'hff00, 16'h0100, 16'h0000, 16'h0000);
        offer_item(OP_ANG,  16'h0001, 16'h8000, 16'h0000, 16'h0000);
        offer_item(OP_ANG,  16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
        offer_item(OP_REAL, 16'h8000, 16'h7fff, 16'hffff, 16'hffff);
        offer_item(OP_IMAG, 16'h7fff, 16'h8000, 16'hffff, 16'hffff);
        offer_item(4'd9,    16'h1111, 16'h2222, 16'h3333, 16'h4444);
        offer_item(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        // random phases: no idling, sender idle, receiver stalls (with one
        // long hold-off), both idle
        random_items(400);
        send_idle_pct = 66;
        random_items(400);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        long_hold = 1'b1;
        random_items(400);
        send_idle_pct = 17;
        recv_stall_pct = 17;
        random_items(400);

        req_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0 || scoreboard.expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Covered %0d items across all actions, %0d responses checked,", sent, seen);
        $display("with sender gaps, receiver stalls and a long back-pressure hold.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout waiting for responses");
        $display("Regression FAIL");
        $finish;
    end

endmodule
